>>> rtl/core/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Shared widths, codes and the saturation helper of the conversion datapath.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_W     = DATA_WIDTH - 2;
   // signed sum of three entries plus one
   localparam int ARG_W      = DATA_WIDTH + 3;
   // radicand arg << FRAC, rounded up to an even width
   localparam int RAD_W      = 2 * DATA_WIDTH;
   localparam int RAD_PAD    = RAD_W - (DATA_WIDTH + 1) - FRAC_W;
   localparam int ROOT_W     = RAD_W / 2;
   // signed difference or sum of two entries
   localparam int NUM_W      = DATA_WIDTH + 1;
   localparam int DEN_W      = ROOT_W + 1;
   localparam int QUO_W      = NUM_W + FRAC_W + 1;
   localparam int DVD_PAD    = QUO_W - NUM_W - FRAC_W;

   typedef logic [1:0] slot_type;
   localparam slot_type SLOT_X = 2'd0;
   localparam slot_type SLOT_Y = 2'd1;
   localparam slot_type SLOT_Z = 2'd2;
   localparam slot_type SLOT_W = 2'd3;

   localparam logic [QUO_W-1:0] NEG_MAG = QUO_W'(1) << (DATA_WIDTH - 1);
   localparam logic [QUO_W-1:0] POS_MAX = NEG_MAG - QUO_W'(1);

   function automatic logic [DATA_WIDTH-1:0] sat_part(input logic neg,
                                                      input logic [QUO_W-1:0] mag);
      logic [DATA_WIDTH-1:0] res;
      if (neg) begin
         if (mag >= NEG_MAG) begin
            res = NEG_MAG[DATA_WIDTH-1:0];
         end else begin
            res = DATA_WIDTH'(0) - mag[DATA_WIDTH-1:0];
         end
      end else begin
         if (mag > POS_MAX) begin
            res = POS_MAX[DATA_WIDTH-1:0];
         end else begin
            res = mag[DATA_WIDTH-1:0];
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/core/rmq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix request channel
// Valid/ready channel carrying the nine entries of one rotation matrix.
// ----------------------------------------------------------------------------
interface rmq_req_if import rmq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] m00;
   logic signed [DATA_WIDTH-1:0] m01;
   logic signed [DATA_WIDTH-1:0] m02;
   logic signed [DATA_WIDTH-1:0] m10;
   logic signed [DATA_WIDTH-1:0] m11;
   logic signed [DATA_WIDTH-1:0] m12;
   logic signed [DATA_WIDTH-1:0] m20;
   logic signed [DATA_WIDTH-1:0] m21;
   logic signed [DATA_WIDTH-1:0] m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 output ready);
endinterface

>>> rtl/core/rmq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion response channel
// Valid/ready channel carrying one quaternion and its invalid flag.
// ----------------------------------------------------------------------------
interface rmq_rsp_if import rmq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] qx;
   logic signed [DATA_WIDTH-1:0] qy;
   logic signed [DATA_WIDTH-1:0] qz;
   logic signed [DATA_WIDTH-1:0] qw;
   logic                         invalid;

   modport source (output valid, qx, qy, qz, qw, invalid, input ready);
   modport sink (input valid, qx, qy, qz, qw, invalid, output ready);
endinterface

>>> rtl/core/rmq_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per register stage, floor(sqrt(rad)).
// ----------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   typedef struct packed {
      logic [ROOT_W+1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sq_stage_type;

   sq_stage_type stage_ff [ROOT_W];
   sq_stage_type stage_in [ROOT_W];

   function automatic sq_stage_type sq_step(input sq_stage_type cur);
      sq_stage_type      nxt;
      logic [ROOT_W+1:0] rem2;
      logic [ROOT_W+1:0] trial;
      rem2  = {cur.rem[ROOT_W-1:0], cur.rad[RAD_W-1 -: 2]};
      trial = {cur.root, 2'b01};
      if (rem2 >= trial) begin
         nxt.rem  = rem2 - trial;
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = rem2;
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
      return nxt;
   endfunction

   always_comb begin
      sq_stage_type head;
      head.rem    = '0;
      head.root   = '0;
      head.rad    = rad;
      stage_in[0] = sq_step(head);
      for (int s = 1; s < ROOT_W; s++) begin
         stage_in[s] = sq_step(stage_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < ROOT_W; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign root = stage_ff[ROOT_W-1].root;

endmodule

>>> rtl/core/rmq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined rounded divider
// Computes ((mag << FRAC) + r) / (2r), one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num_mag,
   input  logic [ROOT_W-1:0] root,
   output logic [QUO_W-1:0]  quo
);

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [QUO_W-1:0] dvd;
      logic [DEN_W-1:0] den;
   } dv_stage_type;

   dv_stage_type stage_ff [QUO_W];
   dv_stage_type stage_in [QUO_W];

   function automatic dv_stage_type dv_step(input dv_stage_type cur);
      dv_stage_type   nxt;
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;
      trial   = {cur.rem, cur.dvd[QUO_W-1]};
      diff    = trial - {1'b0, cur.den};
      ge      = (trial >= {1'b0, cur.den});
      nxt.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nxt.quo = {cur.quo[QUO_W-2:0], ge};
      nxt.dvd = {cur.dvd[QUO_W-2:0], 1'b0};
      nxt.den = cur.den;
      return nxt;
   endfunction

   always_comb begin
      dv_stage_type head;
      head.rem    = '0;
      head.quo    = '0;
      // add half the divisor for round to nearest
      head.dvd    = {{DVD_PAD{1'b0}}, num_mag, {FRAC_W{1'b0}}}
                    + {{(QUO_W-ROOT_W){1'b0}}, root};
      head.den    = {root, 1'b0};
      stage_in[0] = dv_step(head);
      for (int s = 1; s < QUO_W; s++) begin
         stage_in[s] = dv_step(stage_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QUO_W; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign quo = stage_ff[QUO_W-1].quo;

endmodule

>>> rtl/core/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Register order from accept to rsp valid: front, square root, dividers, output.
// Throughput: one transaction per cycle unless the output stalls; every root bit
// and quotient bit has its own register stage, so the ROOT_W square root stages
// and the QUO_W stages of the four dividers set the latency only.
// Reset: synchronous, active high; clears all valid bits, payload not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; (
   input logic   clock,
   input logic   reset,
   rmq_req_if.sink   req_ch,
   rmq_rsp_if.source rsp_ch
);

   localparam int PIPE_D = 1 + ROOT_W + QUO_W;

   // after the front stage: numerators, radicand, root slot
   typedef struct packed {
      logic [3:0][NUM_W-1:0] num;
      logic [RAD_W-1:0]      rad;
      slot_type              slot;
      logic                  invalid;
   } front_type;

   // alongside the square root: numerator signs and magnitudes
   typedef struct packed {
      logic [3:0]            neg;
      logic [3:0][NUM_W-1:0] mag;
      slot_type              slot;
      logic                  invalid;
   } root_side_type;

   // alongside the dividers: signs and half root
   typedef struct packed {
      logic [3:0]        neg;
      logic [ROOT_W-1:0] half;
      slot_type          slot;
      logic              invalid;
   } div_side_type;

   logic          advance;
   logic          valid_ff [PIPE_D];
   front_type     front_ff;
   front_type     front_in;
   root_side_type rside_ff [ROOT_W];
   root_side_type rside_in;
   div_side_type  dside_ff [QUO_W];
   div_side_type  dside_in;
   logic [ROOT_W-1:0]            root;
   logic [3:0][QUO_W-1:0]        quo;
   logic                         out_valid_ff;
   logic [3:0][DATA_WIDTH-1:0]   part_ff;
   logic [3:0][DATA_WIDTH-1:0]   part_in;
   logic                         invalid_ff;

   // whole pipe moves together; hold everything while the output waits
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   function automatic logic signed [ARG_W-1:0] ext_a(input logic signed [DATA_WIDTH-1:0] m);
      return ARG_W'(m);
   endfunction

   function automatic logic signed [NUM_W-1:0] ext_n(input logic signed [DATA_WIDTH-1:0] m);
      return NUM_W'(m);
   endfunction

   // ---------------------------------------------------------------------
   // Front stage: trace test, pivot pick, root argument and numerators
   // ---------------------------------------------------------------------
   always_comb begin
      logic signed [ARG_W-1:0]      trace;
      logic signed [ARG_W-1:0]      arg;
      logic signed [ARG_W-1:0]      one;
      logic signed [DATA_WIDTH-1:0] diag_max;
      slot_type                     piv;
      one      = ARG_W'(1) <<< FRAC_W;
      trace    = ext_a(req_ch.m00) + ext_a(req_ch.m11) + ext_a(req_ch.m22);
      front_in = '0;
      // ties keep the lower index
      piv      = SLOT_X;
      diag_max = req_ch.m00;
      if (req_ch.m11 > req_ch.m00) begin
         piv      = SLOT_Y;
         diag_max = req_ch.m11;
      end
      if (req_ch.m22 > diag_max) begin
         piv = SLOT_Z;
      end
      if (trace > 0) begin
         arg                  = trace + one;
         front_in.slot        = SLOT_W;
         front_in.num[SLOT_X] = ext_n(req_ch.m21) - ext_n(req_ch.m12);
         front_in.num[SLOT_Y] = ext_n(req_ch.m02) - ext_n(req_ch.m20);
         front_in.num[SLOT_Z] = ext_n(req_ch.m10) - ext_n(req_ch.m01);
      end else begin
         front_in.slot = piv;
         unique case (piv)
            SLOT_X: begin
               arg = ext_a(req_ch.m00) - ext_a(req_ch.m11) - ext_a(req_ch.m22) + one;
               front_in.num[SLOT_W] = ext_n(req_ch.m21) - ext_n(req_ch.m12);
               front_in.num[SLOT_Y] = ext_n(req_ch.m10) + ext_n(req_ch.m01);
               front_in.num[SLOT_Z] = ext_n(req_ch.m20) + ext_n(req_ch.m02);
            end
            SLOT_Y: begin
               arg = ext_a(req_ch.m11) - ext_a(req_ch.m22) - ext_a(req_ch.m00) + one;
               front_in.num[SLOT_W] = ext_n(req_ch.m02) - ext_n(req_ch.m20);
               front_in.num[SLOT_Z] = ext_n(req_ch.m21) + ext_n(req_ch.m12);
               front_in.num[SLOT_X] = ext_n(req_ch.m01) + ext_n(req_ch.m10);
            end
            default: begin
               arg = ext_a(req_ch.m22) - ext_a(req_ch.m00) - ext_a(req_ch.m11) + one;
               front_in.num[SLOT_W] = ext_n(req_ch.m10) - ext_n(req_ch.m01);
               front_in.num[SLOT_X] = ext_n(req_ch.m02) + ext_n(req_ch.m20);
               front_in.num[SLOT_Y] = ext_n(req_ch.m12) + ext_n(req_ch.m21);
            end
         endcase
      end
      // drop a non-positive argument: flag it and feed a zero radicand
      if (arg > 0) begin
         front_in.rad = {{RAD_PAD{1'b0}}, arg[DATA_WIDTH:0], {FRAC_W{1'b0}}};
      end else begin
         front_in.rad     = '0;
         front_in.invalid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_ff <= front_in;
      end
   end

   // ---------------------------------------------------------------------
   // Square root, with sign and magnitude of each numerator alongside
   // ---------------------------------------------------------------------
   rmq_sqrt u_sqrt (
      .clock (clock),
      .en    (advance),
      .rad   (front_ff.rad),
      .root  (root)
   );

   always_comb begin
      rside_in.slot    = front_ff.slot;
      rside_in.invalid = front_ff.invalid;
      for (int p = 0; p < 4; p++) begin
         rside_in.neg[p] = front_ff.num[p][NUM_W-1];
         rside_in.mag[p] = front_ff.num[p][NUM_W-1] ? (NUM_W'(0) - front_ff.num[p])
                                                    : front_ff.num[p];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rside_ff[0] <= rside_in;
         for (int s = 1; s < ROOT_W; s++) begin
            rside_ff[s] <= rside_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Dividers, one per quaternion part; the root slot's result is ignored
   // ---------------------------------------------------------------------
   for (genvar p = 0; p < 4; p++) begin : g_div
      rmq_div u_div (
         .clock   (clock),
         .en      (advance),
         .num_mag (rside_ff[ROOT_W-1].mag[p]),
         .root    (root),
         .quo     (quo[p])
      );
   end

   always_comb begin
      logic [ROOT_W:0] r_inc;
      r_inc            = {1'b0, root} + (ROOT_W+1)'(1);
      dside_in.neg     = rside_ff[ROOT_W-1].neg;
      dside_in.slot    = rside_ff[ROOT_W-1].slot;
      dside_in.invalid = rside_ff[ROOT_W-1].invalid;
      // half root, halves round up
      dside_in.half    = r_inc[ROOT_W:1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dside_ff[0] <= dside_in;
         for (int s = 1; s < QUO_W; s++) begin
            dside_ff[s] <= dside_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Valid bits travel with the data
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_D; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_ch.valid;
         for (int s = 1; s < PIPE_D; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[PIPE_D-1];
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: saturate, place the half root, zero on invalid
   // ---------------------------------------------------------------------
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         if (dside_ff[QUO_W-1].invalid) begin
            part_in[p] = '0;
         end else if (dside_ff[QUO_W-1].slot == slot_type'(p)) begin
            part_in[p] = sat_part(1'b0,
                                  {{(QUO_W-ROOT_W){1'b0}}, dside_ff[QUO_W-1].half});
         end else begin
            part_in[p] = sat_part(dside_ff[QUO_W-1].neg[p], quo[p]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         part_ff    <= part_in;
         invalid_ff <= dside_ff[QUO_W-1].invalid;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.qx      = part_ff[SLOT_X];
   assign rsp_ch.qy      = part_ff[SLOT_Y];
   assign rsp_ch.qz      = part_ff[SLOT_Z];
   assign rsp_ch.qw      = part_ff[SLOT_W];
   assign rsp_ch.invalid = invalid_ff;

`ifndef SYNTH
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.invalid |->
         rsp_ch.qx == '0 && rsp_ch.qy == '0 && rsp_ch.qz == '0 && rsp_ch.qw == '0)
      else $error("invalid transaction carries nonzero parts");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready == (!rsp_ch.valid || rsp_ch.ready))
      else $error("input ready does not follow output stall");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");
`endif

endmodule

>>> sim/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion testbench
// Sends matrices through the request channel with random gaps and random
// response stalls. A predictor computes the expected quaternion for every
// accepted matrix, and each response is compared field by field.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
   import rmq_pkg::*;

   localparam int W        = DATA_WIDTH;
   localparam int FR       = W - 2;
   localparam int LATENCY  = 2 + ROOT_W + QUO_W;
   localparam int LIMIT    = 2000000;
   localparam int ONE      = 1 << FR;

   typedef logic signed [W-1:0] part_t;
   typedef struct {
      part_t m [3][3];
   } matrix_t;
   typedef struct {
      part_t qx, qy, qz, qw;
      logic  invalid;
   } quat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmq_req_if req_ch ();
   rmq_rsp_if rsp_ch ();

   rotation_matrix_to_quaternion dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #5 clock = ~clock;

   quat_t  expected_quats [$];
   int     failures = 0;
   longint cycles = 0;
   int     hold_off = 0;   // forced long response stall, cycles left
   bit     stalls_on = 1'b1;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic part_t clamp_part(longint v);
      if (v > (2**(W-1)) - 1) return part_t'((2**(W-1)) - 1);
      if (v < -(2**(W-1))) return part_t'(-(2**(W-1)));
      return part_t'(v);
   endfunction

   // (d << FR) / (2r), halves away from zero
   function automatic part_t div_by_root(longint d, longint unsigned r);
      longint unsigned mag, den, quo;
      mag = (d < 0) ? longint'(-d) : d;
      den = r << 1;
      quo = ((mag << FR) + (den >> 1)) / den;
      return (d < 0) ? clamp_part(-longint'(quo)) : clamp_part(longint'(quo));
   endfunction

   function automatic quat_t convert(matrix_t a);
      longint m [3][3];
      longint q [4];
      longint tr, arg;
      longint unsigned r;
      int i, j, k;
      quat_t res;
      foreach (m[x, y]) m[x][y] = a.m[x][y];
      q = '{0, 0, 0, 0};
      res.invalid = 1'b0;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         r = int_sqrt(longint'(tr + ONE) << FR);
         q[3] = clamp_part(longint'((r + 1) >> 1));
         q[0] = div_by_root(m[2][1] - m[1][2], r);
         q[1] = div_by_root(m[0][2] - m[2][0], r);
         q[2] = div_by_root(m[1][0] - m[0][1], r);
      end else begin
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         arg = m[i][i] - m[j][j] - m[k][k] + ONE;
         if (arg <= 0) begin
            res.invalid = 1'b1;
         end else begin
            r = int_sqrt(arg << FR);
            q[i] = clamp_part(longint'((r + 1) >> 1));
            q[3] = div_by_root(m[k][j] - m[j][k], r);
            q[j] = div_by_root(m[j][i] + m[i][j], r);
            q[k] = div_by_root(m[k][i] + m[i][k], r);
         end
      end
      res.qx = part_t'(q[SLOT_X]);
      res.qy = part_t'(q[SLOT_Y]);
      res.qz = part_t'(q[SLOT_Z]);
      res.qw = part_t'(q[SLOT_W]);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------
   function automatic int random_gap();
      int p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic part_t random_entry();
      case ($urandom_range(0, 5))
         0: return part_t'($urandom);
         1: return part_t'(ONE);
         2: return part_t'(-ONE);
         3: return part_t'($urandom_range(0, 2)) - part_t'(1);
         4: return part_t'((2**(W-1)) - 1 - $urandom_range(0, 1));
         default: return part_t'($urandom_range(0, 2 * ONE)) - part_t'(ONE);
      endcase
   endfunction

   // Roughly orthonormal: cos/sin pair about one axis, permuted
   function automatic matrix_t random_rotation();
      matrix_t a;
      int c, s, ax, p, n;
      c = $urandom_range(0, 2 * ONE) - ONE;
      s = int_sqrt(longint'(ONE) * ONE - longint'(c) * c);
      if ($urandom_range(0, 1)) s = -s;
      ax = $urandom_range(0, 2);
      p = (ax + 1) % 3;
      n = (ax + 2) % 3;
      foreach (a.m[x, y]) a.m[x][y] = '0;
      a.m[ax][ax] = part_t'(ONE);
      a.m[p][p] = part_t'(c);
      a.m[n][n] = part_t'(c);
      a.m[p][n] = part_t'(-s);
      a.m[n][p] = part_t'(s);
      // perturb a few entries
      foreach (a.m[x, y])
         if ($urandom_range(0, 7) == 0)
            a.m[x][y] = a.m[x][y] + part_t'($urandom_range(0, 64)) - part_t'(32);
      return a;
   endfunction

   function automatic matrix_t diag(int d0, int d1, int d2, int off);
      matrix_t a;
      foreach (a.m[x, y]) a.m[x][y] = part_t'(off);
      a.m[0][0] = part_t'(d0);
      a.m[1][1] = part_t'(d1);
      a.m[2][2] = part_t'(d2);
      return a;
   endfunction

   // ------------------------------------------------------------------
   // Driver: one transaction, with a random gap ahead of it
   // ------------------------------------------------------------------
   task automatic send_matrix(matrix_t a, bit gaps);
      int g = gaps ? random_gap() : 0;
      // drop valid over the gap; keep it high when items follow back to back
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.m00 <= a.m[0][0]; req_ch.m01 <= a.m[0][1]; req_ch.m02 <= a.m[0][2];
      req_ch.m10 <= a.m[1][0]; req_ch.m11 <= a.m[1][1]; req_ch.m12 <= a.m[1][2];
      req_ch.m20 <= a.m[2][0]; req_ch.m21 <= a.m[2][1]; req_ch.m22 <= a.m[2][2];
      do @(posedge clock); while (!req_ch.ready);
      expected_quats.push_back(convert(a));
   endtask

   // send back to back, keeping valid high between items
   task automatic send_burst(int count);
      matrix_t a;
      repeat (count) begin
         a = random_rotation();
         req_ch.valid <= 1'b1;
         req_ch.m00 <= a.m[0][0]; req_ch.m01 <= a.m[0][1]; req_ch.m02 <= a.m[0][2];
         req_ch.m10 <= a.m[1][0]; req_ch.m11 <= a.m[1][1]; req_ch.m12 <= a.m[1][2];
         req_ch.m20 <= a.m[2][0]; req_ch.m21 <= a.m[2][1]; req_ch.m22 <= a.m[2][2];
         do @(posedge clock); while (!req_ch.ready);
         expected_quats.push_back(convert(a));
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls, forced hold-off, checking
   // ------------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         stall_left <= random_gap();
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      quat_t e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_quats.size() == 0) begin
            $display("%0t: unexpected response qx=%0d qy=%0d qz=%0d qw=%0d inv=%0b",
                     $time, rsp_ch.qx, rsp_ch.qy, rsp_ch.qz, rsp_ch.qw, rsp_ch.invalid);
            failures++;
         end else begin
            e = expected_quats.pop_front();
            if (rsp_ch.qx !== e.qx || rsp_ch.qy !== e.qy || rsp_ch.qz !== e.qz ||
                rsp_ch.qw !== e.qw || rsp_ch.invalid !== e.invalid) begin
               $display("%0t: mismatch expected %0d %0d %0d %0d inv=%0b, got %0d %0d %0d %0d inv=%0b",
                        $time, e.qx, e.qy, e.qz, e.qw, e.invalid,
                        rsp_ch.qx, rsp_ch.qy, rsp_ch.qz, rsp_ch.qw, rsp_ch.invalid);
               failures++;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles >= LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // identity, positive trace
      send_matrix(diag(ONE, ONE, ONE, 0), 1'b0);
      // each diagonal entry largest, nonpositive trace
      send_matrix(diag(ONE, -ONE, -ONE, 0), 1'b0);
      send_matrix(diag(-ONE, ONE, -ONE, 0), 1'b0);
      send_matrix(diag(-ONE, -ONE, ONE, 0), 1'b0);
      // ties keep the lower index
      send_matrix(diag(0, 0, 0, 100), 1'b0);
      send_matrix(diag(-ONE, 0, 0, -200), 1'b0);
      send_matrix(diag(-100, -50, -50, 300), 1'b0);
      // all-negative diagonal, nonpositive trace; the root argument stays positive
      send_matrix(diag(-32768, -32768, -32768, 0), 1'b0);
      send_matrix(diag(-ONE, -ONE, -ONE, 0), 1'b0);
      // trace of exactly zero and one
      send_matrix(diag(ONE, -ONE, 0, 5), 1'b0);
      send_matrix(diag(1, 0, 0, -7), 1'b0);
      // extremes: saturation of quotients and roots
      send_matrix(diag(32767, 32767, 32767, -32768), 1'b0);
      send_matrix(diag(32767, 32767, 32767, 32767), 1'b0);
      send_matrix(diag(32767, -32768, -32768, 32767), 1'b0);
      send_matrix(diag(-32768, 32767, -32768, -32768), 1'b0);
      send_matrix(diag(-32768, -32768, 32767, 32767), 1'b0);
      send_matrix(diag(-1, -1, -1, -1), 1'b0);
      send_matrix(diag(0, 0, 0, 0), 1'b0);
   endtask

   task automatic test_random(int count);
      matrix_t a;
      repeat (count) begin
         if ($urandom_range(0, 3) != 0) begin
            a = random_rotation();
         end else begin
            foreach (a.m[x, y]) a.m[x][y] = random_entry();
         end
         send_matrix(a, 1'b1);
      end
   endtask

   // hold the response side off while items keep coming, so input stalls
   task automatic test_backpressure();
      hold_off <= 400;
      send_burst(120);
   endtask

   task automatic test_no_stalls();
      stalls_on = 1'b0;
      send_burst(100);
      stalls_on = 1'b1;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.m00, req_ch.m01, req_ch.m02} = '0;
      {req_ch.m10, req_ch.m11, req_ch.m12} = '0;
      {req_ch.m20, req_ch.m21, req_ch.m22} = '0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(350);
      test_backpressure();
      test_random(250);
      test_no_stalls();
      test_random(100);
      req_ch.valid <= 1'b0;

      // drain, then let the pipeline settle
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_req_if.sv
rtl/core/rmq_rsp_if.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion.sv
sim/rotation_matrix_to_quaternion_test.sv
